// ----- sv/tmbt_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the tempo map converter.
// Depends on nothing; every file but tmbt_ram uses it, the testbench by import.
package tmbt_pkg;

  localparam int POINTS_PER_MAP = 64;
  localparam int MAP_COUNT      = 4;
  localparam int BEAT_SECONDS   = 60;

  localparam int IDX_W  = $clog2(POINTS_PER_MAP);
  localparam int CNT_W  = $clog2(POINTS_PER_MAP + 1);
  localparam int MAP_W  = $clog2(MAP_COUNT);
  localparam int DEPTH  = MAP_COUNT * POINTS_PER_MAP;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int POS_W   = 32;
  localparam int TEMPO_W = 25;
  localparam int TIME_W  = 48;
  localparam int FRAC_W  = 24;
  localparam int RATE_W  = 18;
  localparam int HALF_W  = 16;
  localparam int SEC_W   = $clog2(BEAT_SECONDS + 1);
  localparam int NUM_W   = POS_W + SEC_W;
  localparam int DIV_W   = NUM_W + FRAC_W;
  localparam int HI_W    = TIME_W - FRAC_W + RATE_W;
  localparam int LO_W    = FRAC_W + RATE_W;

  localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
  localparam logic [POS_W-1:0]   POS_MAX     = '1;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(120 << 16);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(48000);

  typedef enum logic [1:0] {FN_START, FN_INSERT, FN_BEAT, FN_FRAME} func_t;
  typedef enum logic [1:0] {ST_OK, ST_FULL, ST_SEP} status_t;
  typedef enum logic [2:0] {K_START, K_INSERT, K_BEAT, K_FRAME, K_SEP, K_IGNORE} kind_t;

  typedef enum logic [4:0] {
    BS_IDLE, BS_POS, BS_POS_WAIT, BS_SH_RD, BS_SH_CHK, BS_SH_PUT,
    BS_RC_RD, BS_RC_GET, BS_RC_WR, BS_SP_MUL, BS_SP_DIV, BS_SP_WAIT,
    BS_SC_RD, BS_SC_CHK, BS_BQ_END, BS_FR_RD, BS_FR_MUL, BS_FR_CHK, BS_DONE
  } bstate_t;

  typedef struct packed {
    kind_t               kind;
    logic [MAP_W-1:0]    map;
    logic [HALF_W-1:0]   line;
    logic [HALF_W-1:0]   y;
    logic [HALF_W-1:0]   sep;
    logic [TEMPO_W-1:0]  tempo;
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   frame;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [TEMPO_W-1:0] tempo;
    logic [TIME_W-1:0]  time_q;
  } entry_t;

  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [MAP_W-1:0] m,
                                                 input logic [IDX_W-1:0] i);
    return ADDR_W'(m) * ADDR_W'(POINTS_PER_MAP) + ADDR_W'(i);
  endfunction

endpackage

// ----- sv/tmbt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the change-point tables.
module tmbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/tmbt_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on tmbt_pkg for widths.
module tmbt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tmbt_pkg::DIV_W-1:0]   dividend,
  input  logic [tmbt_pkg::TEMPO_W-1:0] divisor,
  output logic                         done,
  output logic [tmbt_pkg::DIV_W-1:0]   quotient
);
  localparam int DW = tmbt_pkg::DIV_W;
  localparam int VW = tmbt_pkg::TEMPO_W;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem[VW-1:0], quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
        quo <= {quo[DW-2:0], ge};
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end
endmodule

// ----- sv/tmbt_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input words into a holding register and classifies them.
// Depends on tmbt_pkg for the command type.
module tmbt_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [1:0]                         map_select,
  input  logic [tmbt_pkg::HALF_W-1:0]        beat_line,
  input  logic [tmbt_pkg::HALF_W-1:0]        y,
  input  logic [tmbt_pkg::HALF_W-1:0]        separate,
  input  logic [tmbt_pkg::TEMPO_W-1:0]       tempo,
  input  logic [tmbt_pkg::TIME_W-1:0]        start_seconds,
  input  logic [tmbt_pkg::TIME_W-1:0]        frame,
  input  logic                               q_full,
  output logic                               q_push,
  output tmbt_pkg::cmd_t                     q_cmd
);
  logic           hold_v;
  tmbt_pkg::cmd_t hold;
  tmbt_pkg::cmd_t cls;
  logic           accept;

  always_comb begin
    cls.map   = map_select[tmbt_pkg::MAP_W-1:0];
    cls.line  = beat_line;
    cls.y     = y;
    cls.sep   = separate;
    cls.tempo = tempo;
    cls.start = start_seconds;
    cls.frame = frame;
    if (int'(map_select) >= tmbt_pkg::MAP_COUNT) begin
      cls.kind = tmbt_pkg::K_IGNORE;
    end else begin
      unique case (tmbt_pkg::func_t'(func))
        tmbt_pkg::FN_START:  cls.kind = tmbt_pkg::K_START;
        tmbt_pkg::FN_INSERT: cls.kind = (separate == '0) ? tmbt_pkg::K_SEP
                                                         : tmbt_pkg::K_INSERT;
        tmbt_pkg::FN_BEAT:   cls.kind = (separate == '0) ? tmbt_pkg::K_SEP
                                                         : tmbt_pkg::K_BEAT;
        tmbt_pkg::FN_FRAME:  cls.kind = tmbt_pkg::K_FRAME;
      endcase
    end
  end

  assign in_stall = hold_v && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_v && !q_full;
  assign q_cmd    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (accept) begin
      hold_v <= 1'b1;
    end else if (q_push) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= cls;
    end
  end
endmodule

// ----- sv/tmbt_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry command queue between front end and back end.
// Depends on tmbt_pkg for the command type.
module tmbt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmbt_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output tmbt_pkg::cmd_t dout
);
  tmbt_pkg::cmd_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     fill;

  assign full  = fill == 2'd2;
  assign avail = fill != 2'd0;
  assign dout  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= din;
    end
  end
endmodule

// ----- sv/tmbt_back.sv -----
`timescale 1ns / 1ps
// Back end: sequencer that runs one command against the change-point tables.
// Depends on tmbt_pkg, tmbt_ram and tmbt_div.
module tmbt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_avail,
  input  tmbt_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  input  logic [tmbt_pkg::RATE_W-1:0]  rate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tmbt_pkg::TIME_W-1:0]  res_time,
  output logic [tmbt_pkg::TEMPO_W-1:0] res_tempo,
  output tmbt_pkg::status_t            res_status
);
  localparam int PW = tmbt_pkg::POS_W;
  localparam int TW = tmbt_pkg::TIME_W;
  localparam int VW = tmbt_pkg::TEMPO_W;
  localparam int NW = tmbt_pkg::NUM_W;
  localparam int DW = tmbt_pkg::DIV_W;
  localparam int FW = tmbt_pkg::FRAC_W;
  localparam int CW = tmbt_pkg::CNT_W;
  localparam int IW = tmbt_pkg::IDX_W;
  localparam int AW = tmbt_pkg::ADDR_W;
  localparam int HW = tmbt_pkg::HI_W;
  localparam int LW = tmbt_pkg::LO_W;
  localparam int MC = tmbt_pkg::MAP_COUNT;
  localparam int XW = tmbt_pkg::HALF_W;

  tmbt_pkg::bstate_t st, st_next, ret;
  tmbt_pkg::cmd_t    cmd;
  tmbt_pkg::entry_t  prev, cur, rdata, wdata;

  logic [CW-1:0] cnt      [MC];
  logic [VW-1:0] st_tempo [MC];
  logic [TW-1:0] st_time  [MC];

  logic [PW-1:0] pos;
  logic [CW-1:0] i, k, ins_k;
  logic          is_ins;
  logic [PW-1:0] sp_dist;
  logic [VW-1:0] sp_tempo;
  logic [NW-1:0] num;
  logic [TW-1:0] span;
  logic [HW-1:0] prod_hi;
  logic [LW-1:0] prod_lo;

  logic [CW-1:0] cur_cnt;
  logic [TW-1:0] rc_time;
  logic [HW:0]   pframe;
  logic [PW:0]   pos_sum;
  logic          sp_ovf;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_q;
  logic [VW-1:0] div_divisor;

  tmbt_ram #(.WIDTH($bits(tmbt_pkg::entry_t)), .DEPTH(tmbt_pkg::DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  tmbt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  assign cur_cnt = cnt[cmd.map];
  assign rc_time = tmbt_pkg::add_sat(prev.time_q, span);
  assign pframe  = (HW+1)'(prod_hi) + (HW+1)'(prod_lo >> FW);
  assign pos_sum = {1'b0, cmd.line, XW'(0)} + {1'b0, div_q[PW-1:0]};
  assign sp_ovf  = div_q[DW-1:TW] != '0;

  always_ff @(posedge clk) begin
    if (rst) st <= tmbt_pkg::BS_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next      = st;
    q_pop        = 1'b0;
    we           = 1'b0;
    raddr        = tmbt_pkg::ent_addr(cmd.map, i[IW-1:0]);
    waddr        = tmbt_pkg::ent_addr(cmd.map, k[IW-1:0]);
    wdata        = rdata;
    div_start    = 1'b0;
    div_dividend = DW'({cmd.y, XW'(0)});
    div_divisor  = VW'(cmd.sep);
    unique case (st)
      tmbt_pkg::BS_IDLE: begin
        if (q_avail && !out_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            tmbt_pkg::K_START:  st_next = tmbt_pkg::BS_RC_RD;
            tmbt_pkg::K_INSERT: st_next = (int'(cnt[q_cmd.map]) >= tmbt_pkg::POINTS_PER_MAP)
                                          ? tmbt_pkg::BS_DONE : tmbt_pkg::BS_POS;
            tmbt_pkg::K_BEAT:   st_next = tmbt_pkg::BS_POS;
            tmbt_pkg::K_FRAME:  st_next = tmbt_pkg::BS_FR_RD;
            tmbt_pkg::K_SEP,
            tmbt_pkg::K_IGNORE: st_next = tmbt_pkg::BS_DONE;
          endcase
        end
      end
      tmbt_pkg::BS_POS: begin
        div_start = 1'b1;
        st_next   = tmbt_pkg::BS_POS_WAIT;
      end
      tmbt_pkg::BS_POS_WAIT: begin
        if (div_done) begin
          st_next = (cmd.kind == tmbt_pkg::K_INSERT) ? tmbt_pkg::BS_SH_RD
                                                     : tmbt_pkg::BS_SC_RD;
        end
      end
      tmbt_pkg::BS_SH_RD: begin
        raddr = tmbt_pkg::ent_addr(cmd.map, IW'(k - CW'(1)));
        st_next = (k == '0) ? tmbt_pkg::BS_SH_PUT : tmbt_pkg::BS_SH_CHK;
      end
      tmbt_pkg::BS_SH_CHK: begin
        if (rdata.pos > pos) begin
          we      = 1'b1;
          st_next = tmbt_pkg::BS_SH_RD;
        end else begin
          st_next = tmbt_pkg::BS_SH_PUT;
        end
      end
      tmbt_pkg::BS_SH_PUT: begin
        we      = 1'b1;
        wdata   = '{pos: pos, tempo: cmd.tempo, time_q: '0};
        st_next = tmbt_pkg::BS_RC_RD;
      end
      tmbt_pkg::BS_RC_RD: begin
        st_next = (i == cur_cnt) ? tmbt_pkg::BS_DONE : tmbt_pkg::BS_RC_GET;
      end
      tmbt_pkg::BS_RC_GET: st_next = tmbt_pkg::BS_SP_MUL;
      tmbt_pkg::BS_RC_WR: begin
        we      = 1'b1;
        waddr   = tmbt_pkg::ent_addr(cmd.map, i[IW-1:0]);
        wdata   = '{pos: cur.pos, tempo: cur.tempo, time_q: rc_time};
        st_next = tmbt_pkg::BS_RC_RD;
      end
      tmbt_pkg::BS_SP_MUL: begin
        st_next = (sp_tempo == '0) ? ret : tmbt_pkg::BS_SP_DIV;
      end
      tmbt_pkg::BS_SP_DIV: begin
        div_start    = 1'b1;
        div_dividend = {num, FW'(0)};
        div_divisor  = sp_tempo;
        st_next      = tmbt_pkg::BS_SP_WAIT;
      end
      tmbt_pkg::BS_SP_WAIT: begin
        if (div_done) st_next = ret;
      end
      tmbt_pkg::BS_SC_RD: begin
        st_next = (i == cur_cnt) ? tmbt_pkg::BS_SP_MUL : tmbt_pkg::BS_SC_CHK;
      end
      tmbt_pkg::BS_SC_CHK: st_next = tmbt_pkg::BS_SC_RD;
      tmbt_pkg::BS_BQ_END: st_next = tmbt_pkg::BS_DONE;
      tmbt_pkg::BS_FR_RD: begin
        st_next = (i == cur_cnt) ? tmbt_pkg::BS_DONE : tmbt_pkg::BS_FR_MUL;
      end
      tmbt_pkg::BS_FR_MUL: st_next = tmbt_pkg::BS_FR_CHK;
      tmbt_pkg::BS_FR_CHK: st_next = tmbt_pkg::BS_FR_RD;
      tmbt_pkg::BS_DONE:   st_next = tmbt_pkg::BS_IDLE;
    endcase
  end

  // control state: output valid and per-map counts and starts
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int m = 0; m < MC; m++) begin
        cnt[m]      <= '0;
        st_tempo[m] <= tmbt_pkg::TEMPO_RESET;
        st_time[m]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (st == tmbt_pkg::BS_DONE) out_valid <= 1'b1;
      if (q_pop && q_cmd.kind == tmbt_pkg::K_START) begin
        st_tempo[q_cmd.map] <= q_cmd.tempo;
        st_time[q_cmd.map]  <= q_cmd.start;
      end
      if (st == tmbt_pkg::BS_SH_PUT) cnt[cmd.map] <= cur_cnt + CW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st)
      tmbt_pkg::BS_IDLE: begin
        if (q_pop) begin
          cmd        <= q_cmd;
          i          <= '0;
          k          <= cnt[q_cmd.map];
          is_ins     <= 1'b0;
          res_time   <= '0;
          // set start answers its new tempo, frame query starts from the map tempo
          res_tempo  <= (q_cmd.kind == tmbt_pkg::K_START) ? q_cmd.tempo
                      : (q_cmd.kind == tmbt_pkg::K_FRAME) ? st_tempo[q_cmd.map]
                      : '0;
          res_status <= (q_cmd.kind == tmbt_pkg::K_SEP) ? tmbt_pkg::ST_SEP
                      : (q_cmd.kind == tmbt_pkg::K_INSERT &&
                         int'(cnt[q_cmd.map]) >= tmbt_pkg::POINTS_PER_MAP)
                        ? tmbt_pkg::ST_FULL : tmbt_pkg::ST_OK;
          prev       <= (q_cmd.kind == tmbt_pkg::K_START)
                        ? {{PW{1'b0}}, q_cmd.tempo, q_cmd.start}
                        : {{PW{1'b0}}, st_tempo[q_cmd.map], st_time[q_cmd.map]};
        end
      end
      tmbt_pkg::BS_POS_WAIT: begin
        if (div_done) pos <= pos_sum[PW] ? tmbt_pkg::POS_MAX : pos_sum[PW-1:0];
      end
      tmbt_pkg::BS_SH_CHK: begin
        if (rdata.pos > pos) k <= k - CW'(1);
      end
      tmbt_pkg::BS_SH_PUT: begin
        is_ins    <= 1'b1;
        ins_k     <= k;
        res_tempo <= cmd.tempo;
      end
      tmbt_pkg::BS_RC_GET: begin
        cur      <= rdata;
        sp_dist  <= rdata.pos - prev.pos;
        sp_tempo <= prev.tempo;
        ret      <= tmbt_pkg::BS_RC_WR;
      end
      tmbt_pkg::BS_RC_WR: begin
        prev <= '{pos: cur.pos, tempo: cur.tempo, time_q: rc_time};
        if (is_ins && i == ins_k) res_time <= rc_time;
        i <= i + CW'(1);
      end
      tmbt_pkg::BS_SP_MUL: begin
        if (sp_tempo == '0) span <= tmbt_pkg::TIME_MAX;
        else num <= NW'(sp_dist) * NW'(tmbt_pkg::BEAT_SECONDS);
      end
      tmbt_pkg::BS_SP_WAIT: begin
        if (div_done) span <= sp_ovf ? tmbt_pkg::TIME_MAX : div_q[TW-1:0];
      end
      tmbt_pkg::BS_SC_RD: begin
        if (i == cur_cnt) begin
          sp_dist  <= pos - prev.pos;
          sp_tempo <= prev.tempo;
          ret      <= tmbt_pkg::BS_BQ_END;
        end
      end
      tmbt_pkg::BS_SC_CHK: begin
        if (rdata.pos <= pos) prev <= rdata;
        i <= i + CW'(1);
      end
      tmbt_pkg::BS_BQ_END: begin
        res_time  <= rc_time;
        res_tempo <= prev.tempo;
      end
      tmbt_pkg::BS_FR_MUL: begin
        cur     <= rdata;
        prod_hi <= HW'(rdata.time_q[TW-1:FW]) * HW'(rate);
        prod_lo <= LW'(rdata.time_q[FW-1:0]) * LW'(rate);
      end
      tmbt_pkg::BS_FR_CHK: begin
        if (TW'(pframe) <= cmd.frame) res_tempo <= cur.tempo;
        i <= i + CW'(1);
      end
      tmbt_pkg::BS_POS, tmbt_pkg::BS_SH_RD, tmbt_pkg::BS_RC_RD,
      tmbt_pkg::BS_SP_DIV, tmbt_pkg::BS_FR_RD, tmbt_pkg::BS_DONE: ;
    endcase
  end
endmodule

// ----- sv/tempo_map_beat_to_time_unit.sv -----
`timescale 1ns / 1ps
// Tempo map converter, top level: front end, command queue, back end and
// the sample-rate register. Depends on tmbt_pkg and all tmbt_* modules.
//
// Usage:
//  - Input words (func, map_select, position, tempo, start_seconds, frame)
//    move on in_valid/in_stall; a word is taken when in_valid is high and
//    in_stall low. Result words move on out_valid/out_stall; one result
//    per input word, in order.
//  - sample_rate is written on cfg_valid/cfg_ready (ready is always high);
//    write it only while no word is in flight.
//  - The front end holds one word and the queue two more, so input words
//    keep being taken while a result waits on a stalled receiver.
//  - The back end runs one word at a time. Its cost is set by the shared
//    bit-serial divider (62 quotient bits per division) and the single
//    table port: set start and insert walk every change point of the map,
//    insert first finds the position and shifts later points up, a beat
//    query divides for the position and scans the points, a frame query
//    scans the points, and errors go straight to the result.
//  - From acceptance a word passes through the holding register and the
//    queue before the back end takes it.
//  - Synchronous reset clears the queue and output valid, empties every
//    map, sets start tempos to 120 bpm and start times to zero, and sets
//    sample_rate to 48000. No clearing pass is needed.
//  - While out_stall is high the result word holds and the back end waits.
module tempo_map_beat_to_time_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [1:0]                         map_select,
  input  logic [tmbt_pkg::HALF_W-1:0]        beat_line,
  input  logic [tmbt_pkg::HALF_W-1:0]        y,
  input  logic [tmbt_pkg::HALF_W-1:0]        separate,
  input  logic [tmbt_pkg::TEMPO_W-1:0]       tempo,
  input  logic [tmbt_pkg::TIME_W-1:0]        start_seconds,
  input  logic [tmbt_pkg::TIME_W-1:0]        frame,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmbt_pkg::RATE_W-1:0]        sample_rate,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tmbt_pkg::TIME_W-1:0]        time_seconds,
  output logic [tmbt_pkg::TEMPO_W-1:0]       tempo_now,
  output logic [1:0]                         status
);
  logic                  rate_q;
  logic [tmbt_pkg::RATE_W-1:0] rate;
  logic                  q_full, q_push, q_avail, q_pop;
  tmbt_pkg::cmd_t        f_cmd, b_cmd;
  tmbt_pkg::status_t     res_status;

  // Hold the sample rate; take a write whenever it is offered.
  assign cfg_ready = 1'b1;
  assign rate_q    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= tmbt_pkg::RATE_RESET;
    end else if (rate_q) begin
      rate <= sample_rate;
    end
  end

  tmbt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .map_select(map_select), .beat_line(beat_line), .y(y),
    .separate(separate), .tempo(tempo), .start_seconds(start_seconds),
    .frame(frame), .q_full(q_full), .q_push(q_push), .q_cmd(f_cmd)
  );

  // Short queue: lets the front end keep taking words while the back works.
  tmbt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(f_cmd), .full(q_full),
    .pop(q_pop), .avail(q_avail), .dout(b_cmd)
  );

  tmbt_back u_back (
    .clk(clk), .rst(rst), .q_avail(q_avail), .q_cmd(b_cmd), .q_pop(q_pop),
    .rate(rate), .out_valid(out_valid), .out_stall(out_stall),
    .res_time(time_seconds), .res_tempo(tempo_now), .res_status(res_status)
  );

  assign status = res_status;
endmodule

// ----- sv/tmbt_check.sv -----
`timescale 1ns / 1ps
// Port-level checks of the tempo map converter, bound to the top level.
// Depends on tmbt_pkg for the status codes.
module tmbt_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tmbt_pkg::TIME_W-1:0]  time_seconds,
  input logic [tmbt_pkg::TEMPO_W-1:0] tempo_now,
  input logic [1:0]                   status
);
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tmbt_pkg::ST_OK |-> time_seconds == '0 && tempo_now == '0)
    else $error("error result carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_seconds)
                               && $stable(tempo_now) && $stable(status))
    else $error("stalled result changed");
endmodule

bind tempo_map_beat_to_time_unit tmbt_check u_check (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .time_seconds(time_seconds), .tempo_now(tempo_now),
  .status(status)
);

// ----- verif/tempo_map_beat_to_time_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the tempo map converter: random and directed
// words with a built-in predictor. Depends on tmbt_pkg and the unit itself.
module tempo_map_beat_to_time_unit_test;
  import tmbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000; // cycles with no word moving
  localparam int HOLD_CYCLES    = 700;   // long receiver hold-off
  localparam int SMALL_CAP      = 8;     // change points kept in maps 1..3

  typedef struct {
    func_t               fn;
    logic [MAP_W-1:0]    map;
    logic [HALF_W-1:0]   line;
    logic [HALF_W-1:0]   yv;
    logic [HALF_W-1:0]   sep;
    logic [TEMPO_W-1:0]  tempo;
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   frm;
  } request_t;

  typedef struct {
    logic [TIME_W-1:0]  seconds;
    logic [TEMPO_W-1:0] tempo;
    status_t            st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = '0;
  logic [1:0] map_select = '0;
  logic [HALF_W-1:0] beat_line = '0;
  logic [HALF_W-1:0] y = '0;
  logic [HALF_W-1:0] separate = '0;
  logic [TEMPO_W-1:0] tempo = '0;
  logic [TIME_W-1:0] start_seconds = '0;
  logic [TIME_W-1:0] frame = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RATE_W-1:0] sample_rate = RATE_RESET;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] time_seconds;
  logic [TEMPO_W-1:0] tempo_now;
  logic [1:0] status;

  tempo_map_beat_to_time_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .map_select(map_select), .beat_line(beat_line), .y(y),
    .separate(separate), .tempo(tempo), .start_seconds(start_seconds),
    .frame(frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sample_rate(sample_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .time_seconds(time_seconds), .tempo_now(tempo_now), .status(status)
  );

  always #5 clk = ~clk;

  // Predictor copy of the unit's state.
  logic [POS_W-1:0]   pt_pos   [MAP_COUNT][POINTS_PER_MAP];
  logic [TEMPO_W-1:0] pt_tempo [MAP_COUNT][POINTS_PER_MAP];
  logic [TIME_W-1:0]  pt_time  [MAP_COUNT][POINTS_PER_MAP];
  int                 pt_count [MAP_COUNT];
  logic [TEMPO_W-1:0] map_tempo[MAP_COUNT];
  logic [TIME_W-1:0]  map_time [MAP_COUNT];
  logic [RATE_W-1:0]  rate_now;

  request_t pending_words[$];
  answer_t  awaited_answers[$];
  int       planned_points[MAP_COUNT];

  int  errors = 0;
  int  words_taken = 0;
  int  answers_checked = 0;
  int  full_seen = 0;
  int  sep_seen = 0;
  bit  quiet = 1'b0;        // no idling on either side while set
  int  hold_asks = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  function automatic logic [TIME_W-1:0] sum_capped(logic [TIME_W-1:0] a,
                                                   logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Q16.16 beat distance at a Q9.16 tempo, as Q24.24 seconds.
  function automatic logic [TIME_W-1:0] span_seconds(logic [POS_W-1:0] beats,
                                                     logic [TEMPO_W-1:0] bpm);
    logic [63:0] num, q, r, res;
    if (bpm == 0) return TIME_MAX;
    num = 64'(beats) * 64'(BEAT_SECONDS);
    q = num / 64'(bpm);
    r = num % 64'(bpm);
    if (q >= 64'(1) << 24) return TIME_MAX;
    res = (q << 24) + ((r << 24) / 64'(bpm));
    return res > 64'(TIME_MAX) ? TIME_MAX : res[TIME_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] beat_position(logic [HALF_W-1:0] ln,
                                                     logic [HALF_W-1:0] num,
                                                     logic [HALF_W-1:0] den);
    logic [63:0] p;
    p = (64'(ln) << 16) + ((64'(num) << 16) / 64'(den));
    return p > 64'(POS_MAX) ? POS_MAX : p[POS_W-1:0];
  endfunction

  function automatic logic [63:0] frame_of(logic [TIME_W-1:0] t);
    return 64'(t >> 24) * 64'(rate_now) + ((64'(t[23:0]) * 64'(rate_now)) >> 24);
  endfunction

  function automatic void refresh_times(int m);
    for (int i = 0; i < pt_count[m]; i++) begin
      if (i == 0)
        pt_time[m][0] = sum_capped(map_time[m], span_seconds(pt_pos[m][0], map_tempo[m]));
      else
        pt_time[m][i] = sum_capped(pt_time[m][i-1],
            span_seconds(pt_pos[m][i] - pt_pos[m][i-1], pt_tempo[m][i-1]));
    end
  endfunction

  // Apply one word to the predictor and return the answer it owes.
  function automatic answer_t predict_answer(request_t w);
    answer_t a;
    int m, n, k;
    logic [POS_W-1:0] p;
    a.seconds = '0;
    a.tempo = '0;
    a.st = ST_OK;
    m = int'(w.map);
    n = pt_count[m];
    case (w.fn)
      FN_START: begin
        map_tempo[m] = w.tempo;
        map_time[m] = w.start;
        refresh_times(m);
        a.tempo = w.tempo;
      end
      FN_INSERT: begin
        if (w.sep == 0) a.st = ST_SEP;
        else if (n >= POINTS_PER_MAP) a.st = ST_FULL;
        else begin
          p = beat_position(w.line, w.yv, w.sep);
          k = n;
          while (k > 0 && pt_pos[m][k-1] > p) begin
            pt_pos[m][k] = pt_pos[m][k-1];
            pt_tempo[m][k] = pt_tempo[m][k-1];
            pt_time[m][k] = pt_time[m][k-1];
            k--;
          end
          pt_pos[m][k] = p;
          pt_tempo[m][k] = w.tempo;
          pt_count[m] = n + 1;
          refresh_times(m);
          a.seconds = pt_time[m][k];
          a.tempo = w.tempo;
        end
      end
      FN_BEAT: begin
        if (w.sep == 0) a.st = ST_SEP;
        else begin
          p = beat_position(w.line, w.yv, w.sep);
          k = 0;
          for (int i = 0; i < n; i++)
            if (pt_pos[m][i] <= p) k = i + 1;
          if (k == 0) begin
            a.seconds = sum_capped(map_time[m], span_seconds(p, map_tempo[m]));
            a.tempo = map_tempo[m];
          end else begin
            a.seconds = sum_capped(pt_time[m][k-1],
                span_seconds(p - pt_pos[m][k-1], pt_tempo[m][k-1]));
            a.tempo = pt_tempo[m][k-1];
          end
        end
      end
      default: begin
        a.tempo = map_tempo[m];
        for (int i = 0; i < n; i++)
          if (frame_of(pt_time[m][i]) <= 64'(w.frm)) a.tempo = pt_tempo[m][i];
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h (answer %0d)", what, got, want,
             answers_checked);
    errors++;
  endtask

  // Driver: hold the word until taken, then advance from the pending queue.
  always @(posedge clk) begin
    request_t w;
    bit taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        w.fn = func_t'(func);
        w.map = map_select;
        w.line = beat_line;
        w.yv = y;
        w.sep = separate;
        w.tempo = tempo;
        w.start = start_seconds;
        w.frm = frame;
        awaited_answers.insert(awaited_answers.size(), predict_answer(w));
        words_taken++;
      end
      if (!in_valid || taken) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
          w = pending_words.pop_front();
          func <= w.fn;
          map_select <= w.map;
          beat_line <= w.line;
          y <= w.yv;
          separate <= w.sep;
          tempo <= w.tempo;
          start_seconds <= w.start;
          frame <= w.frm;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result word, then pick the next stall.
  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected result", 64'(status), 64'hFFFF);
        end else begin
          a = awaited_answers.pop_front();
          if (time_seconds !== a.seconds)
            report_mismatch("time_seconds", 64'(time_seconds), 64'(a.seconds));
          if (tempo_now !== a.tempo)
            report_mismatch("tempo_now", 64'(tempo_now), 64'(a.tempo));
          if (status !== a.st)
            report_mismatch("status", 64'(status), 64'(a.st));
          if (a.st == ST_FULL) full_seen++;
          if (a.st == ST_SEP) sep_seen++;
        end
        answers_checked++;
      end
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 14);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_words.size() == 0 && awaited_answers.size() == 0 && !in_valid))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic request_t blank_word(func_t fn, int m);
    request_t w;
    w.fn = fn;
    w.map = MAP_W'(m);
    w.line = '0;
    w.yv = '0;
    w.sep = 16'd1;
    w.tempo = TEMPO_RESET;
    w.start = '0;
    w.frm = '0;
    return w;
  endfunction

  task automatic queue_word(request_t w);
    if (w.fn == FN_INSERT && w.sep != 0) planned_points[w.map]++;
    pending_words.insert(pending_words.size(), w);
  endtask

  // Random word: mostly well-formed positions near the start of a map.
  function automatic request_t random_word(bit fill_map0);
    request_t w;
    int pick, m;
    pick = $urandom_range(99);
    m = fill_map0 ? 0 : $urandom_range(MAP_COUNT - 1);
    w = blank_word(FN_BEAT, m);
    if (pick < 8) w.fn = FN_START;
    else if (pick < 40) w.fn = FN_INSERT;
    else if (pick < 78) w.fn = FN_BEAT;
    else w.fn = FN_FRAME;
    // keep the slow operations on small tables
    if (w.fn == FN_INSERT && m != 0 && planned_points[m] >= SMALL_CAP) w.fn = FN_BEAT;
    if (w.fn == FN_INSERT && m == 0 && !fill_map0) w.fn = FN_FRAME;
    if (w.fn == FN_START && m == 0 && !fill_map0) w.map = MAP_W'(1 + $urandom_range(2));
    if ($urandom_range(19) == 0) begin
      w.line = HALF_W'($urandom);
      w.yv = HALF_W'($urandom);
      w.sep = HALF_W'($urandom);
    end else begin
      w.line = HALF_W'($urandom_range(300));
      w.sep = HALF_W'($urandom_range(1, 16));
      w.yv = HALF_W'($urandom_range(0, 20));
    end
    if ($urandom_range(29) == 0) w.sep = '0;
    w.tempo = ($urandom_range(3) == 0) ? TEMPO_W'($urandom_range(65536, 33554431))
                                       : TEMPO_W'($urandom_range(60 << 16, 200 << 16));
    w.start = ($urandom_range(3) == 0) ? {HALF_W'($urandom), 32'($urandom)}
                                       : TIME_W'($urandom_range(0, 32'h3FFF_FFFF));
    case ($urandom_range(3))
      0: w.frm = {HALF_W'($urandom), 32'($urandom)};
      1: w.frm = TIME_W'($urandom_range(0, 2000));
      default: w.frm = TIME_W'($urandom_range(0, 40_000_000));
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || awaited_answers.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    sample_rate <= v;
    do @(posedge clk); while (!cfg_ready);
    rate_now = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    request_t w;
    for (int m = 0; m < MAP_COUNT; m++) begin
      pt_count[m] = 0;
      planned_points[m] = 0;
      map_tempo[m] = TEMPO_RESET;
      map_time[m] = '0;
    end
    rate_now = RATE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-map queries at reset values, extremes, errors, ties.
    queue_word(blank_word(FN_FRAME, 2));
    w = blank_word(FN_BEAT, 3); w.line = 16'd4; queue_word(w);
    w = blank_word(FN_START, 1); w.tempo = TEMPO_W'(65536); queue_word(w);
    w = blank_word(FN_START, 2); w.tempo = '1; w.start = TIME_MAX; queue_word(w);
    w = blank_word(FN_INSERT, 2); w.line = 16'd1; queue_word(w);
    w = blank_word(FN_BEAT, 2); w.line = 16'd9; queue_word(w);
    w = blank_word(FN_INSERT, 1); w.sep = '0; queue_word(w);
    w = blank_word(FN_BEAT, 1); w.sep = '0; queue_word(w);
    w = blank_word(FN_INSERT, 1); w.tempo = TEMPO_W'(90 << 16); queue_word(w);
    w = blank_word(FN_INSERT, 1); w.line = '1; w.yv = '1; w.tempo = '1; queue_word(w);
    w = blank_word(FN_INSERT, 1); w.line = 16'd8; w.yv = 16'd1; w.sep = 16'd3;
    w.tempo = TEMPO_W'(140 << 16); queue_word(w);
    w.tempo = TEMPO_W'(70 << 16); queue_word(w);       // same position again
    w.fn = FN_BEAT; queue_word(w);                       // exactly on a point
    w = blank_word(FN_BEAT, 1); w.line = 16'd7; queue_word(w);
    w = blank_word(FN_BEAT, 1); w.line = '1; w.yv = '1; queue_word(w);
    w = blank_word(FN_BEAT, 1); w.line = 16'd3; w.yv = 16'hFFFF; w.sep = 16'hFFFF;
    queue_word(w);
    w = blank_word(FN_FRAME, 1); queue_word(w);
    w.frm = TIME_MAX; queue_word(w);
    w.frm = TIME_W'(64'd8 * 60 * 192000 / 90); queue_word(w);
    w = blank_word(FN_START, 1); w.start = TIME_W'(64'd5 << 24); queue_word(w);
    w = blank_word(FN_FRAME, 1); w.frm = TIME_W'(2_000_000); queue_word(w);
    write_rate(RATE_W'(192000));

    // Fill map 0 past its capacity, then query it; no idling here.
    write_rate(RATE_W'(8000));
    quiet = 1'b1;
    for (int i = 0; i < POINTS_PER_MAP + 3; i++) begin
      w = random_word(1'b1);
      w.fn = FN_INSERT;
      if (w.sep == 0) w.sep = 16'd2;
      queue_word(w);
    end
    for (int i = 0; i < 40; i++) begin
      w = random_word(1'b1);
      w.fn = (i % 2) ? FN_BEAT : FN_FRAME;
      queue_word(w);
    end
    w = blank_word(FN_START, 0); w.tempo = TEMPO_W'(100 << 16); queue_word(w);
    wait_drained();
    quiet = 1'b0;

    // Random phases over several sample rates, rate extremes among them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_rate('0);
        1: write_rate('1);
        2: write_rate(RATE_W'($urandom_range(8000, 192000)));
        default: write_rate(RATE_RESET);
      endcase
      for (int i = 0; i < 230; i++) queue_word(random_word(1'b0));
      if (ph == 1) begin
        // let the unit back up behind a long receiver hold-off
        repeat (30) @(posedge clk);
        hold_asks++;
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Covered %0d words and %0d results over five sample rates;",
             words_taken, answers_checked);
    $display("%0d table-full and %0d zero-denominator answers seen.", full_seen, sep_seen);
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
